/* design/dark_frame_averager_top_defines.svh */
// Assertion macros shared by the checker of the dark frame averager.
`ifndef DARK_FRAME_AVERAGER_TOP_DEFINES_SVH
`define DARK_FRAME_AVERAGER_TOP_DEFINES_SVH

// Checks a same-edge implication on every rising clock edge outside reset.
`define DFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds on the clock edge after the antecedent.
`define DFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dfa_pkg.sv */
// Shared constants, types and helper functions of the dark frame averager.
package dfa_pkg;

    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int MAX_FRAMES   = 4096;
    localparam int PIXEL_COUNT  = IMAGE_WIDTH * IMAGE_HEIGHT;

    localparam int RAW_W    = 16;
    localparam int ADDR_W   = 18;
    localparam int SUM_W    = 28;
    localparam int MEAN_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int FRAMES_W = 13;
    localparam int FCNT_W   = 12;
    // The remainder of a division stays below the frame count.
    localparam int REM_W    = FRAMES_W - 1;
    // Scaled sum plus half the divisor.
    localparam int NUM_W    = SUM_W + FRAC_W + 1;

    localparam logic [ADDR_W-1:0]   LAST_ADDR    = ADDR_W'(PIXEL_COUNT - 1);
    localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0]   MEAN_MAX     = {MEAN_W{1'b1}};
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(3000);
    localparam logic [FRAMES_W-1:0] FRAMES_MAX   = FRAMES_W'(MAX_FRAMES);
    localparam logic [RAW_W-1:0]    SIGN_FLIP    = RAW_W'(32768);

    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 32;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_FRAMES_ADDR = APB_ADDR_W'(0);

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [ADDR_W-1:0] addr;
        logic              last_pix;
    } t_job;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [ADDR_W-1:0] addr;
        logic              last_pix;
    } t_result;

    typedef struct packed {
        logic              sat;
        logic [REM_W-1:0]  rem;
        logic [MEAN_W-1:0] bits;
        logic [ADDR_W-1:0] addr;
        logic              last_pix;
    } t_div_stage;

    typedef struct packed {
        logic [JOBQ_CNT_W-1:0] level;
        logic                  empty;
    } t_jobq_status;

    // Byte swap followed by a flip of the top bit turns two's complement into unsigned.
    function automatic logic [RAW_W-1:0] decode_word(input logic [RAW_W-1:0] word);
        logic [RAW_W-1:0] swapped;
        swapped = {word[7:0], word[15:8]};
        return swapped ^ SIGN_FLIP;
    endfunction

    function automatic logic [FRAMES_W-1:0] effective_frames(
        input logic [FRAMES_W-1:0] frames
    );
        logic [FRAMES_W-1:0] n;
        n = frames;
        if (frames == '0) begin
            n = FRAMES_W'(1);
        end else if (frames > FRAMES_MAX) begin
            n = FRAMES_MAX;
        end
        return n;
    endfunction

endpackage

/* design/dfa_front.sv */
// Front end: pixel and frame counters, accumulator store and job classification.
module dfa_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [dfa_pkg::RAW_W-1:0]    i_raw_word,
    input  logic [dfa_pkg::FRAMES_W-1:0] i_frames_eff,
    input  dfa_pkg::t_jobq_status        i_q_status,
    output logic                         o_job_push,
    output dfa_pkg::t_job                o_job
);

    logic [dfa_pkg::SUM_W-1:0]  r_mem [dfa_pkg::PIXEL_COUNT];

    logic [dfa_pkg::ADDR_W-1:0] r_pix, n_pix;
    logic [dfa_pkg::FCNT_W-1:0] r_fcnt, n_fcnt;
    // High until the first frame after reset has been accepted in full.
    logic                       r_fresh, n_fresh;
    logic                       w_accept, w_last_frame, w_last_pix;
    logic [dfa_pkg::JOBQ_CNT_W:0] w_committed;

    // Update stage: one item whose stored sum was read at acceptance.
    logic                       r_b_valid;
    logic [dfa_pkg::ADDR_W-1:0] r_b_addr;
    logic [dfa_pkg::RAW_W-1:0]  r_b_sample;
    logic                       r_b_first, r_b_last_frame, r_b_last_pix;
    logic [dfa_pkg::SUM_W-1:0]  r_rd;

    // Last write, for the case of one address read right after it is written.
    logic                       r_w_valid;
    logic [dfa_pkg::ADDR_W-1:0] r_w_addr;
    logic [dfa_pkg::SUM_W-1:0]  r_w_data;

    logic                       w_hazard;
    logic [dfa_pkg::SUM_W-1:0]  w_base, w_sum_sat, w_wdata;
    logic [dfa_pkg::SUM_W:0]    w_sum;

    // Room must remain for the item in the update stage and the new one.
    assign w_committed = {1'b0, i_q_status.level}
                       + {{dfa_pkg::JOBQ_CNT_W{1'b0}}, r_b_valid};
    assign o_full      = (w_committed >= (dfa_pkg::JOBQ_CNT_W + 1)'(dfa_pkg::JOBQ_DEPTH));
    assign w_accept    = i_push && !o_full;

    assign w_last_frame = ({1'b0, r_fcnt} + dfa_pkg::FRAMES_W'(1)) >= i_frames_eff;
    assign w_last_pix   = (r_pix == dfa_pkg::LAST_ADDR);

    always_comb begin
        n_pix   = r_pix;
        n_fcnt  = r_fcnt;
        n_fresh = r_fresh;
        if (w_accept) begin
            if (w_last_pix) begin
                n_pix   = '0;
                n_fresh = 1'b0;
                if (w_last_frame) begin
                    n_fcnt = '0;
                end else begin
                    n_fcnt = r_fcnt + dfa_pkg::FCNT_W'(1);
                end
            end else begin
                n_pix = r_pix + dfa_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix     <= '0;
            r_fcnt    <= '0;
            r_fresh   <= 1'b1;
            r_b_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_pix     <= n_pix;
            r_fcnt    <= n_fcnt;
            r_fresh   <= n_fresh;
            r_b_valid <= w_accept;
            r_w_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_addr       <= r_pix;
            r_b_sample     <= dfa_pkg::decode_word(i_raw_word);
            r_b_first      <= r_fresh;
            r_b_last_frame <= w_last_frame;
            r_b_last_pix   <= w_last_pix;
        end
        r_w_addr <= r_b_addr;
        r_w_data <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_mem[r_pix];
        end
        if (r_b_valid) begin
            r_mem[r_b_addr] <= w_wdata;
        end
    end

    // Pixels arrive in raster order, so the first frame after reset reads only entries
    // that have not been written since reset; those count as zero.
    always_comb begin
        w_hazard  = r_w_valid && (r_w_addr == r_b_addr);
        w_base    = r_b_first ? {dfa_pkg::SUM_W{1'b0}} : (w_hazard ? r_w_data : r_rd);
        w_sum     = {1'b0, w_base} + (dfa_pkg::SUM_W + 1)'(r_b_sample);
        w_sum_sat = w_sum[dfa_pkg::SUM_W] ? dfa_pkg::SUM_MAX : w_sum[dfa_pkg::SUM_W-1:0];
        w_wdata   = r_b_last_frame ? {dfa_pkg::SUM_W{1'b0}} : w_sum_sat;
    end

    assign o_job_push     = r_b_valid && r_b_last_frame;
    assign o_job.sum      = w_sum_sat;
    assign o_job.addr     = r_b_addr;
    assign o_job.last_pix = r_b_last_pix;

endmodule

/* design/dfa_job_queue.sv */
// Short queue of finished sums waiting for the divider.
module dfa_job_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dfa_pkg::t_job         i_job,
    input  logic                  i_pop,
    output dfa_pkg::t_job         o_job,
    output dfa_pkg::t_jobq_status o_status
);

    dfa_pkg::t_job                  r_q [dfa_pkg::JOBQ_DEPTH];
    logic [dfa_pkg::JOBQ_PTR_W-1:0] r_wr, r_rd;
    logic [dfa_pkg::JOBQ_CNT_W-1:0] r_cnt;

    function automatic logic [dfa_pkg::JOBQ_PTR_W-1:0] next_ptr(
        input logic [dfa_pkg::JOBQ_PTR_W-1:0] ptr
    );
        logic [dfa_pkg::JOBQ_PTR_W-1:0] nxt;
        nxt = ptr + dfa_pkg::JOBQ_PTR_W'(1);
        if (ptr == dfa_pkg::JOBQ_PTR_W'(dfa_pkg::JOBQ_DEPTH - 1)) begin
            nxt = '0;
        end
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + dfa_pkg::JOBQ_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - dfa_pkg::JOBQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
    end

    assign o_job          = r_q[r_rd];
    assign o_status.level = r_cnt;
    assign o_status.empty = (r_cnt == '0);

endmodule

/* design/dfa_back.sv */
// Back end: pipelined rounding divider and result queue.
module dfa_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dfa_pkg::FRAMES_W-1:0] i_frames_eff,
    input  dfa_pkg::t_jobq_status        i_q_status,
    input  dfa_pkg::t_job                i_job,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output dfa_pkg::t_result             o_result
);

    localparam int STAGES = dfa_pkg::MEAN_W;

    dfa_pkg::t_div_stage r_stage [STAGES+1];
    dfa_pkg::t_div_stage n_stage [STAGES+1];
    logic                r_vld   [STAGES+1];
    logic                n_vld   [STAGES+1];

    logic [dfa_pkg::REM_W:0] w_trial [1:STAGES];
    logic [dfa_pkg::REM_W:0] w_diff  [1:STAGES];
    logic                    w_ge    [1:STAGES];

    logic [dfa_pkg::NUM_W-1:0] w_num;
    logic                      w_sat, w_take, w_deliver, w_owr;

    dfa_pkg::t_result               r_oq [dfa_pkg::OUTQ_DEPTH];
    dfa_pkg::t_result               w_ores;
    logic [dfa_pkg::OUTQ_PTR_W-1:0] r_owr, r_ord;
    logic [dfa_pkg::OUTQ_CNT_W-1:0] r_ocnt, r_used;

    // Every job taken holds a slot in the result queue until it is delivered.
    assign w_take    = !i_q_status.empty && (r_used < dfa_pkg::OUTQ_CNT_W'(dfa_pkg::OUTQ_DEPTH));
    assign o_q_pop   = w_take;
    assign w_deliver = i_pop && !o_empty;
    assign w_owr     = r_vld[STAGES];

    always_comb begin
        w_num = {1'b0, i_job.sum, {dfa_pkg::FRAC_W{1'b0}}}
              + dfa_pkg::NUM_W'(i_frames_eff >> 1);
        w_sat = w_num >= dfa_pkg::NUM_W'({i_frames_eff, {dfa_pkg::MEAN_W{1'b0}}});

        n_vld[0]            = w_take;
        n_stage[0].sat      = w_sat;
        n_stage[0].rem      = w_num[dfa_pkg::MEAN_W +: dfa_pkg::REM_W];
        n_stage[0].bits     = w_num[dfa_pkg::MEAN_W-1:0];
        n_stage[0].addr     = i_job.addr;
        n_stage[0].last_pix = i_job.last_pix;

        // One quotient bit per stage, shifted in from the bottom.
        for (int i = 1; i <= STAGES; i++) begin
            w_trial[i]      = {r_stage[i-1].rem, r_stage[i-1].bits[dfa_pkg::MEAN_W-1]};
            w_ge[i]         = w_trial[i] >= i_frames_eff;
            w_diff[i]       = w_trial[i] - i_frames_eff;
            n_vld[i]        = r_vld[i-1];
            n_stage[i]      = r_stage[i-1];
            n_stage[i].rem  = w_ge[i] ? w_diff[i][dfa_pkg::REM_W-1:0]
                                      : w_trial[i][dfa_pkg::REM_W-1:0];
            n_stage[i].bits = {r_stage[i-1].bits[dfa_pkg::MEAN_W-2:0], w_ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i <= STAGES; i++) begin
                r_vld[i] <= n_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= STAGES; i++) begin
            r_stage[i] <= n_stage[i];
        end
    end

    assign w_ores.mean     = r_stage[STAGES].sat ? dfa_pkg::MEAN_MAX : r_stage[STAGES].bits;
    assign w_ores.addr     = r_stage[STAGES].addr;
    assign w_ores.last_pix = r_stage[STAGES].last_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
            r_used <= '0;
        end else begin
            if (w_owr) begin
                r_owr <= r_owr + dfa_pkg::OUTQ_PTR_W'(1);
            end
            if (w_deliver) begin
                r_ord <= r_ord + dfa_pkg::OUTQ_PTR_W'(1);
            end
            if (w_owr && !w_deliver) begin
                r_ocnt <= r_ocnt + dfa_pkg::OUTQ_CNT_W'(1);
            end else if (!w_owr && w_deliver) begin
                r_ocnt <= r_ocnt - dfa_pkg::OUTQ_CNT_W'(1);
            end
            if (w_take && !w_deliver) begin
                r_used <= r_used + dfa_pkg::OUTQ_CNT_W'(1);
            end else if (!w_take && w_deliver) begin
                r_used <= r_used - dfa_pkg::OUTQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_owr) begin
            r_oq[r_owr] <= w_ores;
        end
    end

    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_oq[r_ord];

endmodule

/* design/dark_frame_averager_top.sv */
// Top level of the dark frame averager: configuration port and front/back wiring.
//
//  Channel   | Handshake                     | Payload
//  ----------+-------------------------------+----------------------------------------
//  Input     | push / full                   | i_raw_word
//  Result    | pop / empty                   | o_mean_value, o_pixel_index, o_last_pixel
//  Config    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// The block takes one input transfer per clock cycle while full is low and, during the
// last frame of a run, gives one result transfer per clock cycle while pop is high and
// empty is low. The 24-stage divider forms the mean one bit per stage.
// Reset is synchronous and needs no clearing pass: pixels arrive in raster order, so every
// entry read during the first frame after reset is still unwritten and is taken as zero.
// A stalled result side fills the result queue and then the job queue, and only then is
// full raised; the input side never stalls the result side.
module dark_frame_averager_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           push,
    output logic                           full,
    input  logic [dfa_pkg::RAW_W-1:0]      i_raw_word,

    output logic                           empty,
    input  logic                           pop,
    output logic [dfa_pkg::MEAN_W-1:0]     o_mean_value,
    output logic [dfa_pkg::ADDR_W-1:0]     o_pixel_index,
    output logic                           o_last_pixel,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    // Frame count register, as written by software.
    logic [dfa_pkg::FRAMES_W-1:0] r_frames;
    logic [dfa_pkg::FRAMES_W-1:0] w_frames_eff;
    logic                         w_cfg_wr;

    dfa_pkg::t_job         w_front_job, w_queue_job;
    dfa_pkg::t_jobq_status w_q_status;
    dfa_pkg::t_result      w_result;
    logic                  w_job_push, w_job_pop;

    // The access phase is never extended, so the port never inserts waits.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= dfa_pkg::FRAMES_RESET;
        end else if (w_cfg_wr && (paddr == dfa_pkg::REG_FRAMES_ADDR)) begin
            r_frames <= pwdata[dfa_pkg::FRAMES_W-1:0];
        end
    end

    assign prdata = (paddr == dfa_pkg::REG_FRAMES_ADDR)
                  ? dfa_pkg::APB_DATA_W'(r_frames) : '0;

    // A count of zero averages one frame; counts above the maximum are clamped.
    assign w_frames_eff = dfa_pkg::effective_frames(r_frames);

    // The front end counts pixels and frames, accumulates each sample into the store, and
    // hands a job to the queue for each pixel of the last frame of a run.
    dfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_raw_word   (i_raw_word),
        .i_frames_eff (w_frames_eff),
        .i_q_status   (w_q_status),
        .o_job_push   (w_job_push),
        .o_job        (w_front_job)
    );

    dfa_job_queue u_job_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_job    (w_front_job),
        .i_pop    (w_job_pop),
        .o_job    (w_queue_job),
        .o_status (w_q_status)
    );

    // The back end rounds and divides each sum by the frame count and queues the result.
    dfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frames_eff (w_frames_eff),
        .i_q_status   (w_q_status),
        .i_job        (w_queue_job),
        .o_q_pop      (w_job_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (w_result)
    );

    assign o_mean_value  = w_result.mean;
    assign o_pixel_index = w_result.addr;
    assign o_last_pixel  = w_result.last_pix;

endmodule

/* design/dfa_checker.sv */
// Port-level checker of the dark frame averager and its bind to the top level.
`include "dark_frame_averager_top_defines.svh"

module dfa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic [dfa_pkg::MEAN_W-1:0]     o_mean_value,
    input logic [dfa_pkg::ADDR_W-1:0]     o_pixel_index,
    input logic                           o_last_pixel,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [dfa_pkg::APB_ADDR_W-1:0] paddr,
    input logic [dfa_pkg::APB_DATA_W-1:0] pwdata,
    input logic [dfa_pkg::APB_DATA_W-1:0] prdata,
    input logic                           pready
);

    // A waiting result must not vanish or change before it is taken.
    `DFA_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_mean_value) && $stable(o_pixel_index) && $stable(o_last_pixel), "result changed while stalled")

    // The end-of-frame flag belongs to the final raster position only.
    `DFA_ASSERT_NOW(a_last_pixel_index, i_clk, i_rst_n, !empty && o_last_pixel, o_pixel_index == dfa_pkg::LAST_ADDR, "last_pixel on wrong index")

    // Results of one frame come out in raster order without gaps.
    `DFA_ASSERT_NOW(a_raster_order, i_clk, i_rst_n, (pop && !empty && !o_last_pixel) ##1 !empty, o_pixel_index == $past(o_pixel_index) + 1'b1, "result index out of order")

    // A written frame count reads back on the following cycle.
    `DFA_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && (paddr == dfa_pkg::REG_FRAMES_ADDR), (paddr != dfa_pkg::REG_FRAMES_ADDR) || (prdata[dfa_pkg::FRAMES_W-1:0] == $past(pwdata[dfa_pkg::FRAMES_W-1:0])), "frame count readback mismatch")

endmodule

bind dark_frame_averager_top dfa_checker u_dfa_checker (.*);
